[sv/dtf_pkg.sv]
`timescale 1ns / 1ps

package dtf_pkg;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CONV  = 2'd1;
    localparam logic [1:0] CMD_MONO  = 2'd2;

    // Field widths fixed by the interface.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 4;
    localparam int CODE_W  = 16;
    localparam int OFF_W   = 32;

    // Divider: the product magnitude stays below 2^48.
    localparam int NUM_W   = 48;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 50;

    typedef struct packed {
        logic accept;     // latch the incoming transaction, write the table
        logic walk_step;  // advance the table walk by one entry
        logic capture;    // bracketing pair found, latch the differences
        logic mul;        // register the product
        logic prep;       // take sign and magnitude, arm the divider
        logic div_step;   // one restoring division step
        logic finish;     // apply sign and add the base offset
        logic set_oor;    // result is out of range
        logic set_mono;   // result is a monotonicity verdict
        logic mono_val;
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;  // command on the input port
        logic [CMD_W-1:0] cmd;     // latched command
        logic             hit;     // current entry code is above the input code
        logic             first;   // walk is at entry 0
        logic             last;    // walk is at the final entry
        logic             drop;    // current offset is below the previous one
        logic             div_last;
        logic             out_free;
    } t_dp_stat;

endpackage

[sv/dtf_ctrl.sv]
`timescale 1ns / 1ps

module dtf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  dtf_pkg::t_dp_stat   i_stat,
    output dtf_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_cmd == dtf_pkg::CMD_CONV ||
                        i_stat.in_cmd == dtf_pkg::CMD_MONO) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (i_stat.cmd == dtf_pkg::CMD_CONV) begin
                    priority if (i_stat.hit && i_stat.first) begin
                        o_cmd.set_oor = 1'b1;
                        n_state       = ST_DONE;
                    end else if (i_stat.hit) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_MUL;
                    end else if (i_stat.last) begin
                        o_cmd.set_oor = 1'b1;
                        n_state       = ST_DONE;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end else begin
                    priority if (!i_stat.first && i_stat.drop) begin
                        o_cmd.set_mono = 1'b1;
                        o_cmd.mono_val = 1'b0;
                        n_state        = ST_DONE;
                    end else if (i_stat.last) begin
                        o_cmd.set_mono = 1'b1;
                        o_cmd.mono_val = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/dtf_dpath.sv]
`timescale 1ns / 1ps

module dtf_dpath #(
    parameter int LUT_POINTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtf_pkg::t_dp_cmd              i_cmd,
    output dtf_pkg::t_dp_stat             o_stat,
    input  logic [dtf_pkg::CMD_W-1:0]     i_in_cmd,
    input  logic [dtf_pkg::IDX_W-1:0]     i_point_index,
    input  logic [dtf_pkg::CODE_W-1:0]    i_point_code,
    input  logic [dtf_pkg::OFF_W-1:0]     i_point_offset,
    input  logic [dtf_pkg::CODE_W-1:0]    i_dac_code,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [dtf_pkg::OFF_W-1:0]     o_freq_offset,
    output logic                          o_out_of_range,
    output logic                          o_is_monotonic
);

    localparam int AW = $clog2(LUT_POINTS);
    localparam int CW = $clog2(LUT_POINTS + 1);
    localparam int IW = (CW > dtf_pkg::IDX_W) ? CW : dtf_pkg::IDX_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(LUT_POINTS - 1);

    // Table storage; entries not yet written read as zero through the valid bits.
    logic [dtf_pkg::CODE_W-1:0] r_mem_code [LUT_POINTS];
    logic [dtf_pkg::OFF_W-1:0]  r_mem_off  [LUT_POINTS];
    logic [LUT_POINTS-1:0]      r_vld;

    logic [dtf_pkg::CODE_W-1:0] r_q_code;
    logic [dtf_pkg::OFF_W-1:0]  r_q_off;
    logic                       r_q_vld;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;

    logic [dtf_pkg::CMD_W-1:0]  r_cmd;
    logic [dtf_pkg::CODE_W-1:0] r_dac;
    logic [AW-1:0]              r_idx;
    logic [dtf_pkg::CODE_W-1:0] r_prev_code;
    logic signed [dtf_pkg::OFF_W-1:0] r_prev_off;

    logic [dtf_pkg::CODE_W-1:0]       cur_code;
    logic signed [dtf_pkg::OFF_W-1:0] cur_off;

    logic [dtf_pkg::CODE_W-1:0]        r_dd;
    logic signed [dtf_pkg::OFF_W:0]    r_df;
    logic [dtf_pkg::CODE_W-1:0]        r_div;
    logic signed [dtf_pkg::OFF_W-1:0]  r_f0;
    logic signed [dtf_pkg::PROD_W-1:0] r_prod;
    logic signed [dtf_pkg::PROD_W-1:0] prod_mag;
    logic                              r_neg;
    logic [dtf_pkg::NUM_W-1:0]         r_num;
    logic [dtf_pkg::CODE_W-1:0]        r_rem;
    logic [dtf_pkg::CNT_W-1:0]         r_cnt;
    logic [dtf_pkg::CODE_W:0]          trial;
    logic [dtf_pkg::CODE_W:0]          trial_diff;
    logic signed [dtf_pkg::OFF_W:0]    quo_s;
    logic signed [dtf_pkg::OFF_W:0]    sum_s;

    logic [dtf_pkg::OFF_W-1:0] r_freq;
    logic                      r_oor;
    logic                      r_mono;

    assign wr_addr  = AW'(i_point_index);
    assign wr_en    = i_cmd.accept && (i_in_cmd == dtf_pkg::CMD_WRITE) &&
                      (IW'(i_point_index) < IW'(LUT_POINTS));
    assign rd_addr  = i_cmd.walk_step ? (r_idx + AW'(1)) : '0;

    assign cur_code = r_q_vld ? r_q_code : '0;
    assign cur_off  = r_q_vld ? $signed(r_q_off) : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_code[wr_addr] <= i_point_code;
            r_mem_off[wr_addr]  <= i_point_offset;
        end
        r_q_code <= r_mem_code[rd_addr];
        r_q_off  <= r_mem_off[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_q_vld <= r_vld[rd_addr];
        end
    end

    // Table walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd       <= i_in_cmd;
            r_dac       <= i_dac_code;
            r_idx       <= '0;
        end
        if (i_cmd.walk_step) begin
            r_idx       <= r_idx + AW'(1);
            r_prev_code <= cur_code;
            r_prev_off  <= cur_off;
        end
    end

    // Interpolation: (d - c0) * (f1 - f0) / (c1 - c0) + f0.
    assign prod_mag   = r_prod[dtf_pkg::PROD_W-1] ? -r_prod : r_prod;
    assign trial      = {r_rem, r_num[dtf_pkg::NUM_W-1]};
    assign trial_diff = trial - {1'b0, r_div};
    assign quo_s      = r_neg ? -$signed({1'b0, r_num[dtf_pkg::OFF_W-1:0]})
                              :  $signed({1'b0, r_num[dtf_pkg::OFF_W-1:0]});
    assign sum_s      = $signed({r_f0[dtf_pkg::OFF_W-1], r_f0}) + quo_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dd  <= r_dac - r_prev_code;
            r_df  <= $signed({cur_off[dtf_pkg::OFF_W-1], cur_off}) -
                     $signed({r_prev_off[dtf_pkg::OFF_W-1], r_prev_off});
            r_div <= cur_code - r_prev_code;
            r_f0  <= r_prev_off;
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_dd}) * r_df;
        end
        if (i_cmd.prep) begin
            r_neg <= r_prod[dtf_pkg::PROD_W-1];
            r_num <= prod_mag[dtf_pkg::NUM_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + dtf_pkg::CNT_W'(1);
            if (!trial_diff[dtf_pkg::CODE_W]) begin
                r_rem <= trial_diff[dtf_pkg::CODE_W-1:0];
                r_num <= {r_num[dtf_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[dtf_pkg::CODE_W-1:0];
                r_num <= {r_num[dtf_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    // Result and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_freq <= '0;
            r_oor  <= 1'b0;
            r_mono <= 1'b0;
        end
        if (i_cmd.set_oor) begin
            r_oor <= 1'b1;
        end
        if (i_cmd.set_mono) begin
            r_mono <= i_cmd.mono_val;
        end
        if (i_cmd.finish) begin
            r_freq <= sum_s[dtf_pkg::OFF_W-1:0];
        end
        if (i_cmd.load_out) begin
            o_freq_offset  <= r_freq;
            o_out_of_range <= r_oor;
            o_is_monotonic <= r_mono;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.in_cmd   = i_in_cmd;
        o_stat.cmd      = r_cmd;
        o_stat.hit      = (cur_code > r_dac);
        o_stat.first    = (r_idx == '0);
        o_stat.last     = (r_idx == LAST_IDX);
        o_stat.drop     = (cur_off < r_prev_off);
        o_stat.div_last = (r_cnt == dtf_pkg::CNT_W'(dtf_pkg::NUM_W - 1));
        o_stat.out_free = !o_m_valid || i_m_ready;
    end

endmodule

[sv/dac_to_freq_interpolator_unit.sv]
`timescale 1ns / 1ps
// DAC code to frequency offset converter with a piecewise-linear lookup table.
// The input channel (s_axis) carries one command per transaction: the command
// code travels in tuser, the point slot, point code, point offset and DAC code
// in tdata. Every accepted transaction yields exactly one result transaction
// on the output channel (m_axis): the signed offset in parts per trillion in
// tdata, and the out-of-range and monotonic flags in tuser.
// The block works on one transaction at a time. A table write or an unused
// command goes straight to loading its result. A conversion walks the table
// one entry per cycle through the single read port of the table memory, then
// passes through the multiply, the sign handling, the bit-serial divider, the
// final add and the load of the output register; an out-of-range code ends
// right after the walk, as does a monotonicity check. s_axis_tready returns
// together with the result, so the next transaction can be accepted while
// the result is presented.
// After reset every table entry reads as zero and the output is empty.
// The output register holds a finished result while the receiver stalls; the
// block then waits before loading the next one, and s_axis_tready is high only
// while no transaction is in progress.

module dac_to_freq_interpolator_unit #(
    parameter int LUT_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: point_index[3:0], point_code[19:4], point_offset[51:20],
    // dac_code[67:52], zero fill[71:68].
    input  logic [71:0] s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: freq_offset[31:0].
    output logic [31:0] m_axis_tdata,
    // tuser: out_of_range[0], is_monotonic[1].
    output logic [1:0]  m_axis_tuser
);

    dtf_pkg::t_dp_cmd  dp_cmd;
    dtf_pkg::t_dp_stat dp_stat;

    // The controller sequences the walk, the multiply and the divider; the
    // datapath holds the table, the arithmetic and the output register.
    dtf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    dtf_dpath #(
        .LUT_POINTS (LUT_POINTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_in_cmd       (s_axis_tuser),
        .i_point_index  (s_axis_tdata[3:0]),
        .i_point_code   (s_axis_tdata[19:4]),
        .i_point_offset (s_axis_tdata[51:20]),
        .i_dac_code     (s_axis_tdata[67:52]),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_freq_offset  (m_axis_tdata),
        .o_out_of_range (m_axis_tuser[0]),
        .o_is_monotonic (m_axis_tuser[1])
    );

endmodule

[sv/dtf_chk.sv]
`timescale 1ns / 1ps

module dtf_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // An out-of-range conversion reports a zero offset.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("out-of-range result with nonzero offset");

    // No command reports both flags.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both result flags set");

    // Once a transaction is taken, the input closes until it completes.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // A new result appears only as the controller returns to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result loaded while busy");

endmodule

bind dac_to_freq_interpolator_unit dtf_chk u_dtf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
